[rtl/anu2_pkg.sv]
package anu2_pkg;

   localparam int DefaultRoundCount = 25;
   localparam int RoundIdxWidth     = 5;
   localparam int HalfWidth         = 32;
   localparam int KeyWidth          = 128;
   localparam int CsrDataWidth      = 64;
   localparam int CsrIndexWidth     = 2;

   localparam logic [CsrIndexWidth-1:0] CSR_KEY_HIGH = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CSR_KEY_LOW  = CsrIndexWidth'(1);

   typedef logic [3:0] nibble_type;
   localparam nibble_type SBOX [16] = '{
      4'd14, 4'd4, 4'd11, 4'd1, 4'd7, 4'd9, 4'd12, 4'd10,
      4'd13, 4'd2, 4'd0, 4'd15, 4'd8, 4'd5, 4'd3, 4'd6
   };

   typedef struct packed {
      logic [HalfWidth-1:0] plain_left;
      logic [HalfWidth-1:0] plain_right;
   } req_payload_type;

   typedef struct packed {
      logic [HalfWidth-1:0] cipher_left;
      logic [HalfWidth-1:0] cipher_right;
   } rsp_payload_type;

   // One item as it moves down the round pipeline, with its working key.
   typedef struct packed {
      logic [HalfWidth-1:0] left;
      logic [HalfWidth-1:0] right;
      logic [KeyWidth-1:0]  key;
   } stage_type;

   function automatic logic [HalfWidth-1:0] sbox_word(input logic [HalfWidth-1:0] x);
      logic [HalfWidth-1:0] y;
      y = '0;
      for (int i = 0; i < HalfWidth / 4; i++) begin
         y[4*i +: 4] = SBOX[x[4*i +: 4]];
      end
      return y;
   endfunction

   // One cipher round followed by one key schedule step.
   function automatic stage_type round_step(input stage_type s,
                                            input logic [RoundIdxWidth-1:0] idx);
      stage_type            o;
      logic [HalfWidth-1:0] rk1;
      logic [HalfWidth-1:0] rk2;
      logic [HalfWidth-1:0] l1;
      logic [KeyWidth-1:0]  k;
      rk1 = s.key[HalfWidth-1:0];
      rk2 = s.key[2*HalfWidth-1:HalfWidth];
      l1  = sbox_word(s.left) ^ {s.right[2:0], s.right[HalfWidth-1:3]} ^ rk1;
      o.left  = s.right ^ {l1[HalfWidth-11:0], l1[HalfWidth-1:HalfWidth-10]} ^ rk2;
      o.right = l1;
      k = {s.key[KeyWidth-14:0], s.key[KeyWidth-1:KeyWidth-13]};
      k[3:0] = SBOX[k[3:0]];
      k[7:4] = SBOX[k[7:4]];
      k[63:59] = k[63:59] ^ idx;
      o.key = k;
      return o;
   endfunction

endpackage

[rtl/anu2_round.sv]
module anu2_round #(
   parameter int ROUND_INDEX = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 up_valid,
   output logic                 up_ready,
   input  anu2_pkg::stage_type  up_data,
   output logic                 down_valid,
   input  logic                 down_ready,
   output anu2_pkg::stage_type  down_data
);

   logic                valid_ff;
   logic                valid_in;
   anu2_pkg::stage_type data_ff;
   anu2_pkg::stage_type data_in;

   // The stage takes a new item when it is empty or its item moves on.
   assign up_ready = !valid_ff || down_ready;
   assign valid_in = up_ready ? up_valid : valid_ff;
   assign data_in  = anu2_pkg::round_step(up_data,
                        anu2_pkg::RoundIdxWidth'(ROUND_INDEX));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_data  = data_ff;

endmodule

[rtl/anu2_block_encrypt.sv]
// Block encryption engine for a 64-bit lightweight Feistel-style cipher with a
// 128-bit key.
// The key is loaded through the csr_ write port: index 0 takes key bits 127..64
// and index 1 takes bits 63..0. Writes to other indexes are ignored. The key
// should only be changed while no item is in flight.
// Plaintext items enter on the req_ channel and ciphertext items leave on the
// rsp_ channel, both with valid and stall.
// Each pipeline stage performs one round together with one key schedule step,
// and carries its own copy of the working key, so there are ROUND_COUNT stages.
// Items pass through the stage registers in order, and the last stage
// register drives rsp_. A new item can be accepted every cycle unless every
// stage holds an item and rsp_stall is high; the rate is set by the
// one-round-per-stage pipeline.
// When the receiver stalls, the last stage holds its item. Empty stages further
// up keep filling, so req_stall rises only once every stage holds an item.
// Reset clears all stage valid bits and sets the key to zero.
module anu2_block_encrypt #(
   parameter int ROUND_COUNT = anu2_pkg::DefaultRoundCount
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  anu2_pkg::req_payload_type             req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output anu2_pkg::rsp_payload_type             rsp_data,
   input  logic                                  csr_write_en,
   input  logic [anu2_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [anu2_pkg::CsrDataWidth-1:0]     csr_wdata
);

   logic [anu2_pkg::CsrDataWidth-1:0] key_high_ff;
   logic [anu2_pkg::CsrDataWidth-1:0] key_low_ff;

   // Key registers. Writes to indexes outside the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff <= '0;
         key_low_ff  <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            anu2_pkg::CSR_KEY_HIGH: key_high_ff <= csr_wdata;
            anu2_pkg::CSR_KEY_LOW:  key_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Link signals between stages; entry 0 is the pipeline input.
   logic                stage_valid [ROUND_COUNT+1];
   logic                stage_ready [ROUND_COUNT+1];
   anu2_pkg::stage_type stage_data  [ROUND_COUNT+1];

   assign stage_valid[0]           = req_valid;
   assign stage_data[0].left       = req_data.plain_left;
   assign stage_data[0].right      = req_data.plain_right;
   assign stage_data[0].key        = {key_high_ff, key_low_ff};
   assign req_stall                = !stage_ready[0];

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      anu2_round #(
         .ROUND_INDEX(r)
      ) u_round (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (stage_valid[r]),
         .up_ready   (stage_ready[r]),
         .up_data    (stage_data[r]),
         .down_valid (stage_valid[r+1]),
         .down_ready (stage_ready[r+1]),
         .down_data  (stage_data[r+1])
      );
   end

   // The last stage register is the output register.
   assign stage_ready[ROUND_COUNT] = !rsp_stall;
   assign rsp_valid                = stage_valid[ROUND_COUNT];
   assign rsp_data.cipher_left     = stage_data[ROUND_COUNT].left;
   assign rsp_data.cipher_right    = stage_data[ROUND_COUNT].right;

endmodule

[rtl/anu2_checker.sv]
module anu2_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input anu2_pkg::rsp_payload_type rsp_data
);

   // A result that is held back stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A result that is held back keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("result changed while stalled");

   // The pipeline can only back up into the input while the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled although the output is moving");

   // Reset empties the pipeline.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // An input offered while the output is free is always taken.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !rsp_valid |-> !req_stall)
      else $error("input refused while the pipeline has room");

endmodule

bind anu2_block_encrypt anu2_checker u_anu2_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[tb/tb_anu2_block_encrypt.sv]
`timescale 1ns / 1ps

module tb_anu2_block_encrypt;

   // Round count used both for the block instance and for the predictor.
   localparam int ROUNDS = 25;

   // Cycles in a row without any handshake or register write before the run
   // is declared hung. The slowest correct stretch is a long receiver hold of
   // LONG_HOLD_CYCLES plus the pipeline latency, far below this.
   localparam int WATCHDOG_LIMIT = 3000;

   // Length of the deliberate receiver hold that fills the whole pipeline.
   localparam int LONG_HOLD_CYCLES = 150;

   localparam int RANDOM_PHASES = 8;
   localparam int ITEMS_PER_PHASE = 190;

   // Register indexes that decode to nothing; writes there must be ignored.
   localparam logic [anu2_pkg::CsrIndexWidth-1:0] CSR_UNMAPPED_LO =
      anu2_pkg::CsrIndexWidth'(2);
   localparam logic [anu2_pkg::CsrIndexWidth-1:0] CSR_UNMAPPED_HI =
      anu2_pkg::CsrIndexWidth'(3);

   // The 4-bit substitution table, entry i held in bits [4*i +: 4].
   localparam logic [63:0] NIBBLE_SUB = 64'h6358_F02D_AC97_1B4E;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} pacing_type;

   // Keeps its own copy of the key registers, predicts the ciphertext of each
   // accepted plaintext item, and checks returned items in order.
   class cipher_ledger;
      logic [63:0]               key_high;
      logic [63:0]               key_low;
      anu2_pkg::rsp_payload_type expected_ciphers[$];
      int                        error_count;

      function new();
         key_high = '0;
         key_low = '0;
         error_count = 0;
      endfunction

      function void load_register(logic [anu2_pkg::CsrIndexWidth-1:0] idx,
                                  logic [63:0] value);
         if (idx == anu2_pkg::CSR_KEY_HIGH) begin
            key_high = value;
         end else if (idx == anu2_pkg::CSR_KEY_LOW) begin
            key_low = value;
         end
      endfunction

      function logic [31:0] sub_nibbles(logic [31:0] x);
         logic [31:0] y;
         for (int i = 0; i < 8; i++) begin
            y[4*i +: 4] = NIBBLE_SUB[4*x[4*i +: 4] +: 4];
         end
         return y;
      endfunction

      function anu2_pkg::rsp_payload_type encrypt_block(logic [31:0] left_in,
                                                        logic [31:0] right_in);
         logic [31:0]               lh;
         logic [31:0]               rh;
         logic [31:0]               mixed;
         logic [63:0]               kh;
         logic [63:0]               kl;
         logic [63:0]               rot_high;
         logic [63:0]               rot_low;
         logic [4:0]                round_tag;
         anu2_pkg::rsp_payload_type res;
         lh = left_in;
         rh = right_in;
         kh = key_high;
         kl = key_low;
         for (int rnd = 0; rnd < ROUNDS; rnd++) begin
            mixed = sub_nibbles(lh) ^ ((rh >> 3) | (rh << 29)) ^ kl[31:0];
            lh = rh ^ ((mixed << 10) | (mixed >> 22)) ^ kl[63:32];
            rh = mixed;
            // The 128-bit working key turns left by 13, then its low byte
            // goes through the S-box and the round number lands in bits 63..59.
            rot_high = (kh << 13) | (kl >> 51);
            rot_low = (kl << 13) | (kh >> 51);
            kh = rot_high;
            kl = rot_low;
            kl[3:0] = NIBBLE_SUB[4*kl[3:0] +: 4];
            kl[7:4] = NIBBLE_SUB[4*kl[7:4] +: 4];
            round_tag = rnd[4:0];
            kl[63:59] = kl[63:59] ^ round_tag;
         end
         res.cipher_left = lh;
         res.cipher_right = rh;
         return res;
      endfunction

      function void note_plaintext(anu2_pkg::req_payload_type blk);
         expected_ciphers.push_back(encrypt_block(blk.plain_left, blk.plain_right));
      endfunction

      function void check_ciphertext(anu2_pkg::rsp_payload_type got);
         anu2_pkg::rsp_payload_type want;
         if (expected_ciphers.size() == 0) begin
            error_count++;
            if (error_count <= 10) begin
               $display("ERROR: unexpected cipher item %h_%h",
                        got.cipher_left, got.cipher_right);
            end
         end else begin
            want = expected_ciphers.pop_front();
            if (got.cipher_left !== want.cipher_left) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: cipher_left expected %h actual %h",
                           want.cipher_left, got.cipher_left);
               end
            end
            if (got.cipher_right !== want.cipher_right) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("ERROR: cipher_right expected %h actual %h",
                           want.cipher_right, got.cipher_right);
               end
            end
         end
      endfunction

      function int pending();
         return expected_ciphers.size();
      endfunction
   endclass

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                req_valid = 1'b0;
   logic                                req_stall;
   anu2_pkg::req_payload_type           req_data = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 1'b0;
   anu2_pkg::rsp_payload_type           rsp_data;
   logic                                csr_write_en = 1'b0;
   logic [anu2_pkg::CsrIndexWidth-1:0]  csr_index = '0;
   logic [anu2_pkg::CsrDataWidth-1:0]   csr_wdata = '0;

   cipher_ledger ledger;

   // Percent chance per cycle that the sender idles or the receiver stalls.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct = 0;

   // The main process bumps hold_requests to ask for one long receiver hold;
   // the receiver process counts the hold itself.
   int unsigned hold_requests = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   anu2_block_encrypt #(
      .ROUND_COUNT(ROUNDS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_en(csr_write_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver: stall is driven at the falling edge so it is stable when the
   // block samples it. A pending long hold overrides the random stalls.
   always @(negedge clock) begin
      if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = LONG_HOLD_CYCLES;
      end
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // Every ciphertext item accepted at a rising edge is checked against the
   // oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_ciphertext(rsp_data);
      end
   end

   // Watchdog: counts cycles in which nothing at all is accepted.
   initial begin : watchdog
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_en) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("ERROR: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
   end

   task automatic set_pacing(input pacing_type mode);
      send_idle_pct = (mode == IDLE_SENDER) ? 87 : (mode == IDLE_BOTH) ? 33 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 87 : (mode == IDLE_BOTH) ? 33 : 0;
   endtask

   // A register write lasts one cycle; the ledger takes the value at the
   // same rising edge as the block does.
   task automatic write_csr(input logic [anu2_pkg::CsrIndexWidth-1:0] idx,
                            input logic [63:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      ledger.load_register(idx, value);
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Offers one plaintext item, with random idle cycles in front of it, and
   // holds it until the block accepts it. Valid stays high afterwards so
   // back-to-back items go out without a bubble.
   task automatic send_plaintext(input logic [31:0] left_half, input logic [31:0] right_half);
      anu2_pkg::req_payload_type blk;
      blk.plain_left = left_half;
      blk.plain_right = right_half;
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= blk;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      ledger.note_plaintext(blk);
   endtask

   // Drops valid and waits until every predicted ciphertext has come back,
   // which also leaves the pipeline empty for a key change.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   // Corner plaintexts: all zeros, all ones, one half saturated, alternating
   // bits, a counting pattern, and single bits at the extreme ends of each half.
   task automatic send_corners;
      send_plaintext(32'h0000_0000, 32'h0000_0000);
      send_plaintext(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_plaintext(32'hFFFF_FFFF, 32'h0000_0000);
      send_plaintext(32'h0000_0000, 32'hFFFF_FFFF);
      send_plaintext(32'hAAAA_AAAA, 32'h5555_5555);
      send_plaintext(32'h0123_4567, 32'h89AB_CDEF);
      send_plaintext(32'h8000_0000, 32'h0000_0001);
      send_plaintext(32'h0000_0001, 32'h8000_0000);
   endtask

   // Mostly fully random halves; now and then one half is pinned to an
   // extreme so the saturated patterns keep turning up under every key.
   task automatic send_random_phase(input int count);
      int unsigned pick;
      logic [31:0] left_half;
      logic [31:0] right_half;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 15);
         left_half = $urandom;
         right_half = $urandom;
         case (pick)
            0: begin
               left_half = '0;
            end
            1: begin
               left_half = '1;
            end
            2: begin
               right_half = '0;
            end
            3: begin
               right_half = '1;
            end
            default: begin
            end
         endcase
         send_plaintext(left_half, right_half);
      end
   endtask

   initial begin
      ledger = new();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. The key is still zero from reset for the first set of
      // corner items, then every key bit is set for the second set.
      set_pacing(IDLE_NONE);
      send_corners();
      drain();
      write_csr(anu2_pkg::CSR_KEY_HIGH, '1);
      write_csr(anu2_pkg::CSR_KEY_LOW, '1);
      send_corners();
      drain();

      // Writes to indexes that decode to no register must leave the key as
      // it is; a few items under the unchanged key confirm that.
      write_csr(CSR_UNMAPPED_LO, {$urandom, $urandom});
      write_csr(CSR_UNMAPPED_HI, '0);
      send_random_phase(4);
      drain();

      // Random part. Each phase runs under its own key and its own pacing;
      // the pacing cycles through no idling, sender idle, receiver stall and
      // both, so stalls and gaps land on every pipeline position.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            1: begin
               write_csr(anu2_pkg::CSR_KEY_HIGH, '0);
               write_csr(anu2_pkg::CSR_KEY_LOW, '1);
            end
            2: begin
               write_csr(anu2_pkg::CSR_KEY_HIGH, '1);
               write_csr(anu2_pkg::CSR_KEY_LOW, '0);
            end
            default: begin
               write_csr(anu2_pkg::CSR_KEY_HIGH, {$urandom, $urandom});
               write_csr(anu2_pkg::CSR_KEY_LOW, {$urandom, $urandom});
            end
         endcase
         if (p % 3 == 0) begin
            write_csr(($urandom_range(0, 1) != 0) ? CSR_UNMAPPED_LO : CSR_UNMAPPED_HI,
                      {$urandom, $urandom});
         end
         set_pacing(pacing_type'(p % 4));
         // In the first phase the sender never idles, so a long receiver
         // hold fills every stage and pushes back on the input.
         if (p == 0) begin
            hold_requests++;
         end
         send_random_phase(ITEMS_PER_PHASE);
         drain();
      end

      // Let any stray output surface before the verdict.
      set_pacing(IDLE_NONE);
      repeat (ROUNDS + 5) @(posedge clock);

      if (ledger.pending() != 0) begin
         $display("ERROR: %0d cipher items never arrived", ledger.pending());
      end
      if (ledger.error_count == 0 && ledger.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
rtl/anu2_pkg.sv
rtl/anu2_round.sv
rtl/anu2_block_encrypt.sv
rtl/anu2_checker.sv
tb/tb_anu2_block_encrypt.sv
